// ===== rtl/core/llpm_pkg.sv =====
package llpm_pkg;

    // pool geometry
    localparam int POOL_DEPTH = 512;
    localparam int IDX_W      = $clog2(POOL_DEPTH);
    localparam int LINK_W     = IDX_W + 1;
    localparam int LEN_W      = $clog2(POOL_DEPTH + 1);
    localparam int DATA_W     = 32;
    localparam int OP_W       = 3;
    localparam int STATUS_W   = 2;

    // a null link is the pool depth itself
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(POOL_DEPTH);

    // command codes
    localparam logic [OP_W-1:0] OP_INS_FIRST = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_POS   = 3'd1;
    localparam logic [OP_W-1:0] OP_INS_LAST  = 3'd2;
    localparam logic [OP_W-1:0] OP_DEL_FIRST = 3'd3;
    localparam logic [OP_W-1:0] OP_DEL_POS   = 3'd4;
    localparam logic [OP_W-1:0] OP_DEL_LAST  = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_POS = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]          operation;
        logic [IDX_W-1:0]         position;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [IDX_W-1:0]         node_index;
        logic                     head_valid;
        logic [IDX_W-1:0]         head_index;
        logic [LEN_W-1:0]         list_length;
        logic signed [DATA_W-1:0] removed_value;
    } t_res;

endpackage

// ===== rtl/core/linked_list_pool_manager.sv =====
// Singly linked list of signed 32-bit values kept in a pool of POOL_DEPTH nodes.
// A command is taken when start is high and busy is low; exactly one result item
// follows, shown for a single cycle while o_done is high, and it must be captured
// then since the block cannot be held off. Front insert completes in S_CHECK,
// front delete adds one registered read of the head node, and positioned and tail
// commands walk the next links through the link memory, one registered read per
// hop. Errors (pool exhausted, empty list, position past the end) go straight to
// the result and change nothing. Nodes are handed out by a bump allocator and
// never reused.
// busy stays high from acceptance until the cycle before o_done, so the next
// command can be taken while a result is being shown.
module linked_list_pool_manager
    import llpm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    input  t_cmd i_cmd,
    output logic busy,
    output logic o_done,
    output t_res o_res
);

    // sequencer codes
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_CHECK    = 4'd1;  // range checks, front ops
    localparam logic [3:0] S_WALK     = 4'd2;  // issue link read of r_cur
    localparam logic [3:0] S_WALK_WT  = 4'd3;  // step to next node
    localparam logic [3:0] S_INS_WT   = 4'd4;  // write new node
    localparam logic [3:0] S_INS_LINK = 4'd5;  // splice prev to new node
    localparam logic [3:0] S_VIC_WT   = 4'd6;  // victim known, read it
    localparam logic [3:0] S_DEL_WT   = 4'd7;  // unlink victim
    localparam logic [3:0] S_FIN      = 4'd8;  // build result item

    // control state
    logic [3:0]        r_state, n_state;
    logic [LINK_W-1:0] r_head,  n_head;
    logic [LINK_W-1:0] r_free,  n_free;
    logic [LEN_W-1:0]  r_len,   n_len;
    logic              r_done,  n_done;

    // per-command working registers
    t_cmd                     r_cmd,     n_cmd;
    logic [IDX_W-1:0]         r_cur,     n_cur;
    logic [IDX_W-1:0]         r_steps,   n_steps;
    logic                     r_front,   n_front;
    logic [STATUS_W-1:0]      r_status,  n_status;
    logic [IDX_W-1:0]         r_node,    n_node;
    logic signed [DATA_W-1:0] r_removed, n_removed;
    t_res                     r_res,     n_res;

    // memory ports
    logic [IDX_W-1:0]  rd_addr;
    logic              link_we;
    logic [IDX_W-1:0]  link_wa;
    logic [LINK_W-1:0] link_wd;
    logic [LINK_W-1:0] link_rd;
    logic              data_we;
    logic [IDX_W-1:0]  data_wa;
    logic [DATA_W-1:0] data_wd;
    logic [DATA_W-1:0] data_rd;

    logic             is_ins;
    logic             is_del;
    logic [LEN_W-1:0] at;

    llpm_ram #(
        .WIDTH (LINK_W),
        .DEPTH (POOL_DEPTH)
    ) u_link_ram (
        .i_clk     (i_clk),
        .i_wr_en   (link_we),
        .i_wr_addr (link_wa),
        .i_wr_data (link_wd),
        .i_rd_addr (rd_addr),
        .o_rd_data (link_rd)
    );

    llpm_ram #(
        .WIDTH (DATA_W),
        .DEPTH (POOL_DEPTH)
    ) u_data_ram (
        .i_clk     (i_clk),
        .i_wr_en   (data_we),
        .i_wr_addr (data_wa),
        .i_wr_data (data_wd),
        .i_rd_addr (rd_addr),
        .o_rd_data (data_rd)
    );

    assign is_ins = r_cmd.operation inside {OP_INS_FIRST, OP_INS_POS, OP_INS_LAST};
    assign is_del = r_cmd.operation inside {OP_DEL_FIRST, OP_DEL_POS, OP_DEL_LAST};

    // target list position of the command
    always_comb begin
        case (r_cmd.operation)
            OP_INS_FIRST, OP_DEL_FIRST: at = '0;
            OP_INS_POS, OP_DEL_POS:     at = LEN_W'(r_cmd.position);
            OP_INS_LAST:                at = r_len;
            OP_DEL_LAST:                at = r_len - LEN_W'(1);
            default:                    at = '0;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_free    = r_free;
        n_len     = r_len;
        n_done    = 1'b0;
        n_cmd     = r_cmd;
        n_cur     = r_cur;
        n_steps   = r_steps;
        n_front   = r_front;
        n_status  = r_status;
        n_node    = r_node;
        n_removed = r_removed;
        n_res     = r_res;

        rd_addr = r_cur;
        link_we = 1'b0;
        link_wa = r_cur;
        link_wd = NULL_LINK;
        data_we = 1'b0;
        data_wa = r_free[IDX_W-1:0];
        data_wd = r_cmd.value;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd     = i_cmd;
                    n_status  = ST_OK;
                    n_node    = '0;
                    n_removed = '0;
                    n_state   = S_CHECK;
                end
            end

            S_CHECK: begin
                n_cur   = r_head[IDX_W-1:0];
                n_steps = IDX_W'(at - LEN_W'(1));
                rd_addr = r_head[IDX_W-1:0];
                n_state = S_FIN;
                if (is_ins) begin
                    if (r_free == LINK_W'(POOL_DEPTH)) begin
                        n_status = ST_FULL;
                    end else if (at > r_len) begin
                        n_status = ST_BAD_POS;
                    end else if (at == '0) begin
                        data_we = 1'b1;
                        link_we = 1'b1;
                        link_wa = r_free[IDX_W-1:0];
                        link_wd = r_head;
                        n_node  = r_free[IDX_W-1:0];
                        n_head  = r_free;
                        n_free  = r_free + LINK_W'(1);
                        n_len   = r_len + LEN_W'(1);
                    end else begin
                        n_state = S_WALK;
                    end
                end else if (is_del) begin
                    if (r_len == '0) begin
                        n_status = ST_EMPTY;
                    end else if (at >= r_len) begin
                        n_status = ST_BAD_POS;
                    end else if (at == '0) begin
                        // head node read issued here
                        n_front = 1'b1;
                        n_node  = r_head[IDX_W-1:0];
                        n_state = S_DEL_WT;
                    end else begin
                        n_front = 1'b0;
                        n_state = S_WALK;
                    end
                end
            end

            S_WALK: begin
                rd_addr = r_cur;
                if (r_steps == '0) begin
                    n_state = is_ins ? S_INS_WT : S_VIC_WT;
                end else begin
                    n_state = S_WALK_WT;
                end
            end

            S_WALK_WT: begin
                n_cur   = link_rd[IDX_W-1:0];
                n_steps = r_steps - IDX_W'(1);
                n_state = S_WALK;
            end

            S_INS_WT: begin
                // new node takes over the successor of prev
                data_we = 1'b1;
                link_we = 1'b1;
                link_wa = r_free[IDX_W-1:0];
                link_wd = link_rd;
                n_state = S_INS_LINK;
            end

            S_INS_LINK: begin
                link_we = 1'b1;
                link_wa = r_cur;
                link_wd = r_free;
                n_node  = r_free[IDX_W-1:0];
                n_free  = r_free + LINK_W'(1);
                n_len   = r_len + LEN_W'(1);
                n_state = S_FIN;
            end

            S_VIC_WT: begin
                rd_addr = link_rd[IDX_W-1:0];
                n_node  = link_rd[IDX_W-1:0];
                n_state = S_DEL_WT;
            end

            S_DEL_WT: begin
                n_removed = data_rd;
                if (r_front) begin
                    n_head = link_rd;
                end else begin
                    link_we = 1'b1;
                    link_wa = r_cur;
                    link_wd = link_rd;
                end
                n_len   = r_len - LEN_W'(1);
                n_state = S_FIN;
            end

            S_FIN: begin
                n_done              = 1'b1;
                n_res.status        = r_status;
                n_res.node_index    = r_node;
                n_res.head_valid    = (r_head != NULL_LINK);
                n_res.head_index    = (r_head != NULL_LINK) ? r_head[IDX_W-1:0] : '0;
                n_res.list_length   = r_len;
                n_res.removed_value = r_removed;
                n_state             = S_IDLE;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= NULL_LINK;
            r_free  <= '0;
            r_len   <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_free  <= n_free;
            r_len   <= n_len;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_cur     <= n_cur;
        r_steps   <= n_steps;
        r_front   <= n_front;
        r_status  <= n_status;
        r_node    <= n_node;
        r_removed <= n_removed;
        r_res     <= n_res;
    end

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== rtl/core/llpm_ram.sv =====
module llpm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/llpm_chk.sv =====
module llpm_chk
    import llpm_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input t_cmd i_cmd,
    input logic busy,
    input logic o_done,
    input t_res o_res
);

    // accepted command keeps the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not raise busy");

    // one result item per strobe
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe longer than one cycle");

    // empty list reports zero head and length
    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_res.head_valid |-> o_res.head_index == '0 && o_res.list_length == '0)
        else $error("empty list with nonzero head or length");

    // failed commands report no node and no removed data
    a_err_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_res.status != ST_OK |-> o_res.node_index == '0 &&
            o_res.removed_value == '0)
        else $error("error result carries node or data");

endmodule

bind linked_list_pool_manager llpm_chk u_llpm_chk (.*);
